FILE: rtl/kms_pkg.sv
// shared types, op codes, port numbers and the key code map for the keyboard matrix scanner
// no dependencies
package kms_pkg;

  localparam int unsigned ROWS = 8;
  localparam int unsigned COLS = 8;

  typedef logic [1:0] op_t;
  localparam op_t OP_SAMPLE    = 2'd0;
  localparam op_t OP_WR_SCAN   = 2'd1;
  localparam op_t OP_WR_DIR    = 2'd2;
  localparam op_t OP_READ_PORT = 2'd3;

  localparam logic [7:0] PORT_ROWS = 8'h0E;
  localparam logic [7:0] PORT_COLS = 8'h0F;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // direction bits 7..6 select the port roles
  localparam logic [1:0] DIR_NORMAL     = 2'b01;
  localparam logic [1:0] DIR_TRANSPOSED = 2'b10;

  // modifier positions in the matrix
  localparam logic [2:0] CTRL_ROW  = 3'd5;
  localparam logic [2:0] CTRL_BIT  = 3'd6;
  localparam logic [2:0] SHIFT_ROW = 3'd6;
  localparam logic [2:0] SHIFT_BIT = 3'd7;

  typedef logic [ROWS-1:0][COLS-1:0] matrix_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] key_code;
    logic       shift_key;
    logic       ctrl_key;
    logic [7:0] port_addr;
    logic [7:0] write_value;
  } item_t;

  typedef struct packed {
    logic       mapped;
    logic [2:0] row;
    logic [2:0] col;
  } key_pos_t;

  function automatic key_pos_t key_lookup(input logic [5:0] code);
    key_pos_t p;
    p = '0;
    case (code)
      6'd1:  p = {1'b1, 3'd5, 3'd4};
      6'd2:  p = {1'b1, 3'd4, 3'd5};
      6'd3:  p = {1'b1, 3'd4, 3'd4};
      6'd4:  p = {1'b1, 3'd3, 3'd5};
      6'd5:  p = {1'b1, 3'd3, 3'd4};
      6'd6:  p = {1'b1, 3'd2, 3'd5};
      6'd7:  p = {1'b1, 3'd2, 3'd4};
      6'd8:  p = {1'b1, 3'd1, 3'd5};
      6'd9:  p = {1'b1, 3'd1, 3'd4};
      6'd10: p = {1'b1, 3'd0, 3'd5};
      6'd11: p = {1'b1, 3'd5, 3'd7};
      6'd12: p = {1'b1, 3'd2, 3'd1};
      6'd13: p = {1'b1, 3'd3, 3'd1};
      6'd14: p = {1'b1, 3'd4, 3'd7};
      6'd15: p = {1'b1, 3'd4, 3'd6};
      6'd16: p = {1'b1, 3'd3, 3'd2};
      6'd17: p = {1'b1, 3'd3, 3'd7};
      6'd18: p = {1'b1, 3'd2, 3'd2};
      6'd19: p = {1'b1, 3'd1, 3'd3};
      6'd20: p = {1'b1, 3'd2, 3'd7};
      6'd21: p = {1'b1, 3'd1, 3'd2};
      6'd22: p = {1'b1, 3'd1, 3'd7};
      6'd23: p = {1'b1, 3'd1, 3'd1};
      6'd24: p = {1'b1, 3'd2, 3'd0};
      6'd25: p = {1'b1, 3'd1, 3'd6};
      6'd26: p = {1'b1, 3'd0, 3'd3};
      6'd27: p = {1'b1, 3'd5, 3'd3};
      6'd28: p = {1'b1, 3'd3, 3'd3};
      6'd29: p = {1'b1, 3'd4, 3'd2};
      6'd30: p = {1'b1, 3'd3, 3'd6};
      6'd31: p = {1'b1, 3'd2, 3'd6};
      6'd32: p = {1'b1, 3'd3, 3'd0};
      6'd33: p = {1'b1, 3'd4, 3'd3};
      6'd34: p = {1'b1, 3'd4, 3'd0};
      6'd35: p = {1'b1, 3'd2, 3'd3};
      6'd36: p = {1'b1, 3'd4, 3'd1};
      6'd37: p = {1'b1, 3'd0, 3'd0};
      6'd38: p = {1'b1, 3'd5, 3'd1};
      6'd39: p = {1'b1, 3'd5, 3'd2};
      6'd40: p = {1'b1, 3'd5, 3'd5};
      6'd41: p = {1'b1, 3'd5, 3'd0};
      6'd42: p = {1'b1, 3'd0, 3'd6};
      6'd43: p = {1'b1, 3'd0, 3'd4};
      6'd44: p = {1'b1, 3'd0, 3'd2};
      6'd45: p = {1'b1, 3'd1, 3'd0};
      6'd46: p = {1'b1, 3'd0, 3'd1};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/kms_if.sv
// valid/ready channel interfaces for the keyboard matrix scanner
// depends on kms_pkg
interface kms_in_if;
  logic             valid;
  logic             ready;
  kms_pkg::op_t     op;
  logic [5:0]       key_code;
  logic             shift_key;
  logic             ctrl_key;
  logic [7:0]       port_addr;
  logic [7:0]       write_value;

  modport source (output valid, op, key_code, shift_key, ctrl_key, port_addr, write_value,
                  input ready);
  modport sink (input valid, op, key_code, shift_key, ctrl_key, port_addr, write_value,
                output ready);
endinterface

interface kms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

FILE: rtl/kms_state.sv
// key matrix, scan and direction registers, updated by sample and write beats
// depends on kms_pkg
module kms_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd_en,
  input  kms_pkg::item_t   item,
  output kms_pkg::matrix_t matrix,
  output logic [7:0]       scan,
  output logic [7:0]       dir
);
  import kms_pkg::*;

  matrix_t    matrix_r, matrix_nxt, sample_m;
  logic [7:0] scan_r, scan_nxt;
  logic [7:0] dir_r, dir_nxt;
  key_pos_t   pos;

  assign pos = key_lookup(item.key_code);

  // fresh matrix: one mapped key plus modifiers
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        sample_m[r][c] = pos.mapped && (pos.row == 3'(r)) && (pos.col == 3'(c));
      end
    end
    if (item.ctrl_key) sample_m[CTRL_ROW][CTRL_BIT] = 1'b1;
    if (item.shift_key) sample_m[SHIFT_ROW][SHIFT_BIT] = 1'b1;
  end

  always_comb begin
    matrix_nxt = matrix_r;
    scan_nxt   = scan_r;
    dir_nxt    = dir_r;
    if (upd_en) begin
      unique case (item.op)
        OP_SAMPLE:    matrix_nxt = sample_m;
        OP_WR_SCAN:   scan_nxt   = item.write_value;
        OP_WR_DIR:    dir_nxt    = item.write_value;
        OP_READ_PORT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
      scan_r   <= '0;
      dir_r    <= '0;
    end else begin
      matrix_r <= matrix_nxt;
      scan_r   <= scan_nxt;
      dir_r    <= dir_nxt;
    end
  end

  assign matrix = matrix_r;
  assign scan   = scan_r;
  assign dir    = dir_r;
endmodule

FILE: rtl/kms_read.sv
// port read logic: row or column reduction of the selected matrix lines
// depends on kms_pkg
module kms_read (
  input  kms_pkg::matrix_t matrix,
  input  logic [7:0]       scan,
  input  logic [7:0]       dir,
  input  logic [7:0]       port_addr,
  output logic [7:0]       read_data
);
  import kms_pkg::*;

  logic [COLS-1:0] col_acc;
  logic [ROWS-1:0] row_acc;

  always_comb begin
    col_acc = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (!scan[r]) col_acc = col_acc | matrix[r];
    end
    // transposed: a row reports if any of its unmasked columns is set
    for (int r = 0; r < ROWS; r++) begin
      row_acc[r] = |(matrix[r] & ~scan);
    end
  end

  always_comb begin
    read_data = IDLE_BYTE;
    if (port_addr == PORT_COLS) begin
      if (dir[7]) read_data = scan;
      else if (dir[7:6] == DIR_NORMAL) read_data = IDLE_BYTE ^ col_acc;
    end else if (port_addr == PORT_ROWS) begin
      if (dir[6]) read_data = scan;
      else if (dir[7:6] == DIR_TRANSPOSED) read_data = IDLE_BYTE ^ row_acc;
    end
  end
endmodule

FILE: rtl/keyboard_matrix_scanner.sv
// keyboard matrix scanner top level: input register, state, port read and result register
// depends on kms_pkg, kms_if, kms_state, kms_read
//
// usage
//   in_if carries one bus beat per item: op 0 samples the keys (clears the matrix, sets
//   the mapped key and the ctrl/shift bits), op 1 loads the scan register, op 2 loads the
//   direction register, op 3 reads the port in port_addr.
//   out_if carries one read_data beat for each op 3 beat, in order; other ops give none.
//   an accepted beat is held in the input register; state updates and the read result
//   are registered from there, and read_data is driven by the result register, which
//   loads as the beat leaves the input register.
//   one beat per cycle is sustained unless a read waits on a stalled out_if; the single
//   result register sets that figure. when out_if stalls, a pending read holds in the
//   input register and in_if.ready drops until the result register drains; sample and
//   write beats pass a stalled output only while no read waits ahead of them.
//   synchronous reset clears the key matrix, scan and direction registers and both
//   valid flags.
module keyboard_matrix_scanner (
  input logic    clk,
  input logic    rst_n,
  kms_in_if.sink   in_if,
  kms_out_if.source out_if
);
  import kms_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  item_t      s1_item_r, s1_item_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  matrix_t    matrix;
  logic [7:0] scan;
  logic [7:0] dir;
  logic [7:0] rd_byte;
  logic       is_read;
  logic       out_free;
  logic       s1_go;
  logic       in_take;

  assign is_read  = (s1_item_r.op == OP_READ_PORT);
  assign out_free = !out_valid_r || out_if.ready;
  assign s1_go    = s1_valid_r && (!is_read || out_free);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_take  = in_if.valid && in_if.ready;

  kms_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_go),
    .item   (s1_item_r),
    .matrix (matrix),
    .scan   (scan),
    .dir    (dir)
  );

  kms_read u_read (
    .matrix    (matrix),
    .scan      (scan),
    .dir       (dir),
    .port_addr (s1_item_r.port_addr),
    .read_data (rd_byte)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = '{op: in_if.op, key_code: in_if.key_code, shift_key: in_if.shift_key,
                       ctrl_key: in_if.ctrl_key, port_addr: in_if.port_addr,
                       write_value: in_if.write_value};
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;
    if (s1_go && is_read) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.read_data = out_data_r;
endmodule

FILE: tb/keyboard_matrix_scanner_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for keyboard_matrix_scanner: bus beats in, port reads checked out
// depends on kms_pkg, kms_if and the keyboard_matrix_scanner rtl
module keyboard_matrix_scanner_tb;
  import kms_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TIMEOUT_NS   = 5_000_000;

  // key code 1..46 -> {row, col}, written as octal digit pairs
  localparam logic [5:0] KEY_SPOT [1:46] = '{
    6'o54, 6'o45, 6'o44, 6'o35, 6'o34, 6'o25, 6'o24, 6'o15,
    6'o14, 6'o05, 6'o57, 6'o21, 6'o31, 6'o47, 6'o46, 6'o32,
    6'o37, 6'o22, 6'o13, 6'o27, 6'o12, 6'o17, 6'o11, 6'o20,
    6'o16, 6'o03, 6'o53, 6'o33, 6'o42, 6'o36, 6'o26, 6'o30,
    6'o43, 6'o40, 6'o23, 6'o41, 6'o00, 6'o51, 6'o52, 6'o55,
    6'o50, 6'o06, 6'o04, 6'o02, 6'o10, 6'o01
  };

  logic clk;
  logic rst_n;

  kms_in_if  in_bus ();
  kms_out_if out_bus ();

  keyboard_matrix_scanner u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // mirror of the block state
  logic [7:0] key_rows [8];
  logic [7:0] scan_reg;
  logic [7:0] dir_reg;
  logic [7:0] expected_reads [$];

  int   errors = 0;
  int   beats_sent = 0;
  bit   in_gaps = 1'b1;
  bit   out_stalls = 1'b1;
  bit   hold_req = 1'b0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] port_read(input logic [7:0] port);
    logic [7:0] acc;
    acc = '0;
    if (port == PORT_COLS) begin
      if (dir_reg[7]) return scan_reg;
      if (dir_reg[7:6] == DIR_NORMAL) begin
        for (int r = 0; r < 8; r++)
          if (!scan_reg[r]) acc |= key_rows[r];
      end
    end else if (port == PORT_ROWS) begin
      if (dir_reg[6]) return scan_reg;
      if (dir_reg[7:6] == DIR_TRANSPOSED) begin
        // each unmasked column folds its key bits onto the row index
        for (int c = 0; c < 8; c++)
          for (int r = 0; r < 8; r++)
            if (!scan_reg[c] && key_rows[r][c]) acc[r] = 1'b1;
      end
    end
    return IDLE_BYTE ^ acc;
  endfunction

  task automatic apply_beat(input item_t it);
    logic [5:0] spot;
    case (it.op)
      OP_SAMPLE: begin
        for (int r = 0; r < 8; r++) key_rows[r] = '0;
        if (it.key_code >= 6'd1 && it.key_code <= 6'd46) begin
          spot = KEY_SPOT[it.key_code];
          key_rows[spot[5:3]][spot[2:0]] = 1'b1;
        end
        if (it.ctrl_key) key_rows[CTRL_ROW][CTRL_BIT] = 1'b1;
        if (it.shift_key) key_rows[SHIFT_ROW][SHIFT_BIT] = 1'b1;
      end
      OP_WR_SCAN: scan_reg = it.write_value;
      OP_WR_DIR: dir_reg = it.write_value;
      OP_READ_PORT: expected_reads.push_back(port_read(it.port_addr));
    endcase
  endtask

  function automatic item_t beat_of(input op_t op, input logic [5:0] code, input logic sh,
                                    input logic ct, input logic [7:0] port,
                                    input logic [7:0] val);
    item_t it;
    it.op = op;
    it.key_code = code;
    it.shift_key = sh;
    it.ctrl_key = ct;
    it.port_addr = port;
    it.write_value = val;
    return it;
  endfunction

  function automatic item_t pick_beat(input op_t op);
    item_t it;
    it.op = op;
    it.key_code = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(1, 46));
    it.shift_key = 1'($urandom_range(0, 1));
    it.ctrl_key = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0)
      it.port_addr = 8'($urandom_range(0, 255));
    else
      it.port_addr = $urandom_range(0, 1) ? PORT_ROWS : PORT_COLS;
    it.write_value = 8'($urandom);
    // steer the mode bits towards the two scanning modes
    if (op == OP_WR_DIR && $urandom_range(0, 3) != 0)
      it.write_value[7:6] = $urandom_range(0, 1) ? DIR_NORMAL : DIR_TRANSPOSED;
    // a single open line makes hits easy to tell apart
    if (op == OP_WR_SCAN && $urandom_range(0, 2) == 0)
      it.write_value = ~(8'h01 << $urandom_range(0, 7));
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input item_t it);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.op          <= it.op;
    in_bus.key_code    <= it.key_code;
    in_bus.shift_key   <= it.shift_key;
    in_bus.ctrl_key    <= it.ctrl_key;
    in_bus.port_addr   <= it.port_addr;
    in_bus.write_value <= it.write_value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    apply_beat(it);
    beats_sent++;
  endtask

  // always waits for a clock edge first so the next beat is driven in a later step
  task automatic wait_drained();
    int n;
    n = 0;
    in_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (expected_reads.size() != 0 && n < DRAIN_LIMIT);
    if (expected_reads.size() != 0) begin
      $error("read_data: %0d reads never returned", expected_reads.size());
      errors++;
      expected_reads.delete();
    end
  endtask

  task automatic test_idle_ports();
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_ROWS, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, 8'hFF, 8'hFF));
    wait_drained();
  endtask

  task automatic test_key_decode();
    // normal mode, every row open
    send_beat(beat_of(OP_WR_DIR, 6'd0, 1'b0, 1'b0, 8'h00, 8'h40));
    send_beat(beat_of(OP_WR_SCAN, 6'd0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(OP_SAMPLE, 6'd1, 1'b1, 1'b1, 8'h00, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    send_beat(beat_of(OP_SAMPLE, 6'd46, 1'b0, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    // no key, modifiers alone, and unmapped codes
    send_beat(beat_of(OP_SAMPLE, 6'd0, 1'b1, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    send_beat(beat_of(OP_SAMPLE, 6'd63, 1'b0, 1'b1, 8'hFF, 8'hFF));
    send_beat(beat_of(OP_READ_PORT, 6'd63, 1'b1, 1'b1, PORT_COLS, 8'hFF));
    send_beat(beat_of(OP_SAMPLE, 6'd47, 1'b1, 1'b1, 8'h00, 8'h00));
    send_beat(beat_of(OP_WR_SCAN, 6'd0, 1'b0, 1'b0, 8'h00, 8'hFF));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    // transposed mode
    send_beat(beat_of(OP_WR_DIR, 6'd0, 1'b0, 1'b0, 8'h00, 8'h80));
    send_beat(beat_of(OP_WR_SCAN, 6'd0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(OP_SAMPLE, 6'd37, 1'b1, 1'b0, 8'h00, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_ROWS, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    // both ports as outputs echo the scan byte
    send_beat(beat_of(OP_WR_DIR, 6'd0, 1'b0, 1'b0, 8'h00, 8'hC0));
    send_beat(beat_of(OP_WR_SCAN, 6'd0, 1'b0, 1'b0, 8'h00, 8'hA5));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_ROWS, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    // low direction bits only
    send_beat(beat_of(OP_WR_DIR, 6'd0, 1'b0, 1'b0, 8'h00, 8'h3F));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_COLS, 8'h00));
    send_beat(beat_of(OP_READ_PORT, 6'd0, 1'b0, 1'b0, PORT_ROWS, 8'h00));
    wait_drained();
  endtask

  task automatic test_random_scans(input int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        send_beat(pick_beat(OP_SAMPLE));
        send_beat(pick_beat(OP_WR_SCAN));
        if ($urandom_range(0, 2) == 0) send_beat(pick_beat(OP_WR_DIR));
        repeat ($urandom_range(1, 4)) send_beat(pick_beat(OP_READ_PORT));
      end else begin
        send_beat(pick_beat(op_t'($urandom_range(0, 3))));
      end
    end
    wait_drained();
  endtask

  task automatic test_output_hold();
    in_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0)
        send_beat(pick_beat(op_t'($urandom_range(0, 2))));
      else
        send_beat(pick_beat(OP_READ_PORT));
    end
    wait_drained();
    in_gaps = 1'b1;
  endtask

  task automatic test_full_rate(input int n);
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    repeat (n) send_beat(pick_beat(op_t'($urandom_range(0, 3))));
    wait_drained();
  endtask

  // result side: random stall bursts plus one long hold on request
  initial begin : read_sink
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (out_stalls && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : read_check
    logic [7:0] want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_reads.size() == 0) begin
        $error("read_data: expected none, actual %02h", out_bus.read_data);
        errors++;
      end else begin
        want = expected_reads.pop_front();
        if (out_bus.read_data !== want) begin
          $error("read_data: expected %02h, actual %02h", want, out_bus.read_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int r = 0; r < 8; r++) key_rows[r] = '0;
    scan_reg = '0;
    dir_reg  = '0;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.op          <= OP_SAMPLE;
    in_bus.key_code    <= '0;
    in_bus.shift_key   <= 1'b0;
    in_bus.ctrl_key    <= 1'b0;
    in_bus.port_addr   <= '0;
    in_bus.write_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ports();
    test_key_decode();
    test_random_scans(650);
    test_output_hold();
    test_random_scans(50);
    test_full_rate(100);

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
